@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, sampled on the rising edge, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/core/iqfp_pkg.sv @@
`timescale 1ns / 1ps

package iqfp_pkg;

    localparam int FRAME_BYTES_MAX = 14;
    localparam int BYTE_CNT_W      = 4;

    localparam logic [7:0]  START_HI   = 8'hFF;
    localparam logic [7:0]  STOP_HI    = 8'hF0;
    localparam logic [7:0]  MARK_LO    = 8'h00;
    localparam logic [10:0] HDR_FTR_LEN = 11'd10;
    localparam logic [15:0] MAX_FRAME_LEN_RST = 16'd1030;

    localparam logic [15:0] SAT_POS = 16'h7FFF;
    localparam logic [15:0] SAT_NEG = 16'h8000;

    localparam logic [BYTE_CNT_W-1:0] CNT_TAP      = 4'd4;
    localparam logic [BYTE_CNT_W-1:0] CNT_TAP_HDR  = 4'd10;
    localparam logic [BYTE_CNT_W-1:0] CNT_TAP_FTR  = 4'd8;
    localparam logic [BYTE_CNT_W-1:0] CNT_TAP_BOTH = 4'd14;

    typedef enum logic [1:0] {
        REG_TX_ID         = 2'd0,
        REG_TAP_COUNT     = 2'd1,
        REG_MAX_FRAME_LEN = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]         antenna_id;
        logic signed [31:0] sample_i;
        logic signed [31:0] sample_q;
    } req_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       run_last;
        logic       frame_end;
    } rsp_t;

    // bytes of one request, element 0 goes out first
    typedef struct packed {
        logic [FRAME_BYTES_MAX-1:0][7:0] bytes;
        logic [BYTE_CNT_W-1:0]           cnt;
        logic                            fend;
    } burst_t;

endpackage

@@ rtl/core/iqfp_sat_lane.sv @@
`timescale 1ns / 1ps

module iqfp_sat_lane
    import iqfp_pkg::*;
(
    input  logic signed [31:0] sample,
    output logic [15:0]        sat
);

    logic fits;

    // fits in int16 when the top 17 bits all agree
    assign fits = (sample[31:15] == '0) || (sample[31:15] == '1);

    always_comb
    begin
        if (fits)
        begin
            sat = sample[15:0];
        end
        else if (sample[31])
        begin
            sat = SAT_NEG;
        end
        else
        begin
            sat = SAT_POS;
        end
    end

endmodule

@@ rtl/core/iqfp_burst_asm.sv @@
`timescale 1ns / 1ps

module iqfp_burst_asm
    import iqfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic        first,
    input  logic        last,
    input  logic [7:0]  tx_id,
    input  logic [7:0]  antenna_id,
    input  logic [15:0] sat_i,
    input  logic [15:0] sat_q,
    input  logic        take,
    output logic        pend_valid,
    output burst_t      pend
);

    logic [5:0][7:0] hdr;
    logic [3:0][7:0] pl;
    logic [3:0][7:0] ftr;
    burst_t          burst;
    logic            pend_valid_reg;
    logic            pend_valid_next;
    burst_t          pend_reg;

    assign hdr = {antenna_id, tx_id, MARK_LO, START_HI, MARK_LO, START_HI};
    assign pl  = {sat_q[15:8], sat_q[7:0], sat_i[15:8], sat_i[7:0]};
    assign ftr = {MARK_LO, STOP_HI, MARK_LO, STOP_HI};

    always_comb
    begin
        burst.fend = last;
        unique case ({first, last})
            2'b11:
            begin
                burst.bytes = {ftr, pl, hdr};
                burst.cnt   = CNT_TAP_BOTH;
            end
            2'b10:
            begin
                burst.bytes = {32'h0, pl, hdr};
                burst.cnt   = CNT_TAP_HDR;
            end
            2'b01:
            begin
                burst.bytes = {48'h0, ftr, pl};
                burst.cnt   = CNT_TAP_FTR;
            end
            default:
            begin
                burst.bytes = {80'h0, pl};
                burst.cnt   = CNT_TAP;
            end
        endcase
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (take)
        begin
            pend_valid_next = 1'b0;
        end
        if (load)
        begin
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pend_reg <= burst;
        end
    end

    assign pend_valid = pend_valid_reg;
    assign pend       = pend_reg;

endmodule

@@ rtl/core/iqfp_byte_shifter.sv @@
`timescale 1ns / 1ps

module iqfp_byte_shifter
    import iqfp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pend_valid,
    input  burst_t pend,
    output logic   take,
    output logic   rsp_valid,
    input  logic   rsp_stall,
    output rsp_t   rsp
);

    logic [FRAME_BYTES_MAX-1:0][7:0] bytes_reg;
    logic [FRAME_BYTES_MAX-1:0][7:0] bytes_next;
    logic [BYTE_CNT_W-1:0]           cnt_reg;
    logic [BYTE_CNT_W-1:0]           cnt_next;
    logic                            fend_reg;
    logic                            fend_next;
    logic                            busy;
    logic                            last_byte;
    logic                            pop;

    assign busy      = (cnt_reg != '0);
    assign last_byte = (cnt_reg == BYTE_CNT_W'(1));
    assign pop       = busy && !rsp_stall;
    // next burst moves in as the current one drains its final byte
    assign take      = pend_valid && (!busy || (pop && last_byte));

    always_comb
    begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        fend_next  = fend_reg;
        if (take)
        begin
            bytes_next = pend.bytes;
            cnt_next   = pend.cnt;
            fend_next  = pend.fend;
        end
        else if (pop)
        begin
            bytes_next = bytes_reg >> 8;
            cnt_next   = cnt_reg - BYTE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        fend_reg  <= fend_next;
    end

    assign rsp_valid     = busy;
    assign rsp.data_byte = bytes_reg[0];
    assign rsp.run_last  = last_byte;
    assign rsp.frame_end = last_byte && fend_reg;

endmodule

@@ rtl/core/iq_sample_frame_packer.sv @@
`timescale 1ns / 1ps

// Frame packer for channel taps: each accepted request (one tap, 32-bit I and Q plus an
// antenna id) is turned into a burst of bytes on a byte-wide response port: start marker,
// tx id and antenna id on the first tap of a frame, four saturated little-endian sample
// bytes on every tap, and the stop marker on the last tap. The I and Q lanes saturate in
// parallel and a merge stage lines up the burst in a holding register; a shift register
// then drains it one byte per cycle while rsp_stall is low. The byte port sets the rate:
// a mid-frame tap sends 4 bytes, a first tap 10, a last tap 8 and a one-tap frame 14. A
// dropped tap (tap count zero or frame longer than max_frame_len) is taken and sends
// nothing. A request is taken while the previous burst is still draining; the first
// byte passes the holding register, then the shift register. cfg_ready is always high.

`include "assert_macros.svh"

module iq_sample_frame_packer
    import iqfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [7:0]  tx_id_reg;
    logic [7:0]  tap_count_reg;
    logic [15:0] max_frame_len_reg;
    logic [7:0]  taps_seen_reg;
    logic [7:0]  taps_seen_next;

    logic        accept;
    logic        enabled;
    logic        first_tap;
    logic        last_tap;
    logic        emit;
    logic [10:0] frame_bytes;
    logic [8:0]  seen_inc;
    logic [15:0] sat_i;
    logic [15:0] sat_q;
    logic        take;
    logic        pend_valid;
    burst_t      pend;

    assign cfg_ready = 1'b1;
    assign req_stall = pend_valid;
    assign accept    = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_id_reg         <= '0;
            tap_count_reg     <= '0;
            max_frame_len_reg <= MAX_FRAME_LEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TX_ID:         tx_id_reg         <= cfg_data[7:0];
                REG_TAP_COUNT:     tap_count_reg     <= cfg_data[7:0];
                REG_MAX_FRAME_LEN: max_frame_len_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign enabled     = (tap_count_reg != '0);
    assign frame_bytes = {1'b0, tap_count_reg, 2'b00} + HDR_FTR_LEN;
    assign emit        = enabled && ({5'd0, frame_bytes} <= max_frame_len_reg);
    assign first_tap   = (taps_seen_reg == '0);
    assign seen_inc    = {1'b0, taps_seen_reg} + 9'd1;
    // a lowered tap count closes the frame on the next tap
    assign last_tap    = (seen_inc >= {1'b0, tap_count_reg});

    always_comb
    begin
        taps_seen_next = taps_seen_reg;
        if (accept)
        begin
            if (!enabled || last_tap)
            begin
                taps_seen_next = '0;
            end
            else
            begin
                taps_seen_next = seen_inc[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_seen_reg <= '0;
        end
        else
        begin
            taps_seen_reg <= taps_seen_next;
        end
    end

    iqfp_sat_lane u_lane_i (
        .sample (req.sample_i),
        .sat    (sat_i)
    );

    iqfp_sat_lane u_lane_q (
        .sample (req.sample_q),
        .sat    (sat_q)
    );

    iqfp_burst_asm u_asm (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept && emit),
        .first      (first_tap),
        .last       (last_tap),
        .tx_id      (tx_id_reg),
        .antenna_id (req.antenna_id),
        .sat_i      (sat_i),
        .sat_q      (sat_q),
        .take       (take),
        .pend_valid (pend_valid),
        .pend       (pend)
    );

    iqfp_byte_shifter u_shift (
        .clk        (clk),
        .rst_n      (rst_n),
        .pend_valid (pend_valid),
        .pend       (pend),
        .take       (take),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

    `ASSERT_IMPLY(a_fend_is_run_last, clk, rst_n, rsp_valid && rsp.frame_end, rsp.run_last)
    `ASSERT_NEXT(a_emit_holds_request, clk, rst_n, accept && emit, pend_valid)
    `ASSERT_NEXT(a_frame_wraps, clk, rst_n, accept && last_tap, taps_seen_reg == '0)
    `ASSERT_IMPLY(a_take_only_pending, clk, rst_n, take, pend_valid && !accept)

endmodule
